@@ sv/i2cm_pkg.sv @@
// Package for the I2C register-access master: request/result payload
// types, bus sequencer state type, phase and header-step codes.
// No dependencies; used by every module of the block.
package i2cm_pkg;

  // Width of the per-phase tick counter
  localparam int unsigned TickCountWidth = 16;
  // Width of the half-period register
  localparam int unsigned HalfWidth      = 16;
  localparam int unsigned DevAddrWidth   = 7;
  localparam int unsigned CfgIdxWidth    = 1;
  localparam int unsigned CfgDataWidth   = 16;
  // Phase-length compare width: covers both the register and the cap
  localparam int unsigned LimWidth =
      ((TickCountWidth > HalfWidth) ? TickCountWidth : HalfWidth) + 1;

  localparam logic [DevAddrWidth-1:0] DevAddrReset = 7'h48;
  localparam logic [HalfWidth-1:0]    HalfReset    = 16'd10;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CfgDevAddr    = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CfgHalfPeriod = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_STA_HI,
    PH_STA_FALL,
    PH_TX_LO,
    PH_TX_HI,
    PH_TXACK_LO,
    PH_TXACK_HI,
    PH_RX_LO,
    PH_RX_HI,
    PH_RXACK_LO,
    PH_RXACK_HI,
    PH_STOP_LO,
    PH_STOP_HI,
    PH_STOP_REL
  } phase_e;

  typedef enum logic [2:0] {
    HS_ADDR_W,
    HS_REG,
    HS_VALUE,
    HS_MID_STOP,
    HS_ADDR_R,
    HS_FINAL
  } hstep_e;

  typedef struct packed {
    logic       cmd_valid;
    logic       mode;
    logic [7:0] reg_addr;
    logic [7:0] write_value;
    logic [7:0] read_count;
    logic       sda_in;
  } i2cm_req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] read_byte;
    logic       byte_last;
    logic       done_res;
    logic       ack_error;
  } i2cm_res_t;

  typedef struct packed {
    phase_e                    phase;
    logic [TickCountWidth-1:0] tick_count;
    logic [3:0]                bit_index;
    hstep_e                    header_step;
    logic [7:0]                bytes_left;
    logic [7:0]                shift_reg;
    logic [7:0]                saved_reg;
    logic [7:0]                saved_value;
    logic                      saved_mode;
    logic                      error_flag;
  } i2cm_state_t;

endpackage

@@ sv/i2cm_step.sv @@
// Next-state and pin-level result logic of the I2C bus sequencer for one tick.
// Purely combinational; depends on i2cm_pkg.
module i2cm_step (
  input  i2cm_pkg::i2cm_state_t                  st_q_i,
  input  i2cm_pkg::i2cm_req_t                    req_i,
  input  logic [i2cm_pkg::DevAddrWidth-1:0]      dev_addr_i,
  input  logic [i2cm_pkg::HalfWidth-1:0]         half_ticks_i,
  output i2cm_pkg::i2cm_state_t                  st_d_o,
  output i2cm_pkg::i2cm_res_t                    res_o
);
  import i2cm_pkg::*;

  localparam logic [LimWidth-1:0] LimCap = LimWidth'(1) << TickCountWidth;

  logic [LimWidth-1:0] lim_raw;
  logic [LimWidth-1:0] limit;
  logic [LimWidth-1:0] tick_next;
  logic                tick_end;
  logic [3:0]          bit_next;
  logic [7:0]          rx_shift;
  logic [7:0]          left_next;
  logic [7:0]          addr_w;

  // Phase length: zero acts as one, capped at the counter range
  always_comb begin
    lim_raw = LimWidth'(half_ticks_i);
    if (lim_raw == '0) begin
      limit = LimWidth'(1);
    end else if (lim_raw > LimCap) begin
      limit = LimCap;
    end else begin
      limit = lim_raw;
    end
    tick_next = LimWidth'(st_q_i.tick_count) + LimWidth'(1);
    tick_end  = (tick_next >= limit);
  end

  assign bit_next  = st_q_i.bit_index + 4'd1;
  assign rx_shift  = {st_q_i.shift_reg[6:0], req_i.sda_in};
  assign left_next = st_q_i.bytes_left - 8'd1;
  assign addr_w    = {dev_addr_i, 1'b0};

  always_comb begin
    st_d_o          = st_q_i;
    res_o           = '0;
    res_o.scl_out   = 1'b1;
    res_o.sda_out   = 1'b1;
    res_o.sda_drive = 1'b1;
    res_o.busy_res  = 1'b1;

    if (st_q_i.phase == PH_IDLE) begin
      // Idle: both lines driven high, a command starts a transaction
      res_o.busy_res = req_i.cmd_valid;
      if (req_i.cmd_valid) begin
        st_d_o.saved_mode  = req_i.mode;
        st_d_o.saved_reg   = req_i.reg_addr;
        st_d_o.saved_value = req_i.write_value;
        st_d_o.bytes_left  = (req_i.read_count == 8'd0) ? 8'd1 : req_i.read_count;
        st_d_o.error_flag  = 1'b0;
        st_d_o.header_step = HS_ADDR_W;
        st_d_o.tick_count  = '0;
        st_d_o.phase       = PH_STA_HI;
      end
    end else begin
      // Pin levels for the current phase
      unique case (st_q_i.phase)
        PH_STA_HI:   begin res_o.scl_out = 1'b1; res_o.sda_out = 1'b1; end
        PH_STA_FALL: begin res_o.scl_out = 1'b1; res_o.sda_out = 1'b0; end
        PH_TX_LO, PH_TX_HI: begin
          res_o.scl_out = (st_q_i.phase == PH_TX_HI);
          res_o.sda_out = st_q_i.shift_reg[3'd7 - st_q_i.bit_index[2:0]];
        end
        PH_TXACK_LO, PH_RX_LO: begin
          res_o.scl_out   = 1'b0;
          res_o.sda_drive = 1'b0;
        end
        PH_TXACK_HI, PH_RX_HI: begin
          res_o.scl_out   = 1'b1;
          res_o.sda_drive = 1'b0;
        end
        PH_RXACK_LO, PH_RXACK_HI: begin
          res_o.scl_out = (st_q_i.phase == PH_RXACK_HI);
          // NAK the last byte, ACK the others
          res_o.sda_out = (st_q_i.bytes_left <= 8'd1);
        end
        PH_STOP_LO:  begin res_o.scl_out = 1'b0; res_o.sda_out = 1'b0; end
        PH_STOP_HI:  begin res_o.scl_out = 1'b1; res_o.sda_out = 1'b0; end
        default:     begin res_o.scl_out = 1'b1; res_o.sda_out = 1'b1; end
      endcase

      if (!tick_end) begin
        st_d_o.tick_count = tick_next[TickCountWidth-1:0];
      end else begin
        st_d_o.tick_count = '0;
        // Phase transitions at the end of each phase
        unique case (st_q_i.phase)
          PH_STA_HI: st_d_o.phase = PH_STA_FALL;
          PH_STA_FALL: begin
            st_d_o.shift_reg = (st_q_i.header_step == HS_ADDR_R) ?
                               {dev_addr_i, 1'b1} : addr_w;
            st_d_o.bit_index = '0;
            st_d_o.phase     = PH_TX_LO;
          end
          PH_TX_LO: st_d_o.phase = PH_TX_HI;
          PH_TX_HI: begin
            st_d_o.bit_index = bit_next;
            st_d_o.phase     = bit_next[3] ? PH_TXACK_LO : PH_TX_LO;
          end
          PH_TXACK_LO: st_d_o.phase = PH_TXACK_HI;
          PH_TXACK_HI: begin
            if (req_i.sda_in) begin
              st_d_o.error_flag = 1'b1;
            end
            if (st_q_i.header_step == HS_ADDR_W) begin
              st_d_o.header_step = HS_REG;
              st_d_o.shift_reg   = st_q_i.saved_reg;
              st_d_o.bit_index   = '0;
              st_d_o.phase       = PH_TX_LO;
            end else if (st_q_i.header_step == HS_REG) begin
              if (st_q_i.saved_mode) begin
                st_d_o.header_step = HS_MID_STOP;
                st_d_o.phase       = PH_STOP_LO;
              end else begin
                st_d_o.header_step = HS_VALUE;
                st_d_o.shift_reg   = st_q_i.saved_value;
                st_d_o.bit_index   = '0;
                st_d_o.phase       = PH_TX_LO;
              end
            end else if (st_q_i.header_step == HS_ADDR_R) begin
              st_d_o.header_step = HS_FINAL;
              st_d_o.shift_reg   = '0;
              st_d_o.bit_index   = '0;
              st_d_o.phase       = PH_RX_LO;
            end else begin
              st_d_o.header_step = HS_FINAL;
              st_d_o.phase       = PH_STOP_LO;
            end
          end
          PH_RX_LO: st_d_o.phase = PH_RX_HI;
          PH_RX_HI: begin
            st_d_o.shift_reg = rx_shift;
            st_d_o.bit_index = bit_next;
            if (bit_next[3]) begin
              res_o.byte_valid = 1'b1;
              res_o.read_byte  = rx_shift;
              res_o.byte_last  = (st_q_i.bytes_left <= 8'd1);
              st_d_o.phase     = PH_RXACK_LO;
            end else begin
              st_d_o.phase     = PH_RX_LO;
            end
          end
          PH_RXACK_LO: st_d_o.phase = PH_RXACK_HI;
          PH_RXACK_HI: begin
            st_d_o.bytes_left = left_next;
            if (left_next == 8'd0) begin
              st_d_o.phase = PH_STOP_LO;
            end else begin
              st_d_o.shift_reg = '0;
              st_d_o.bit_index = '0;
              st_d_o.phase     = PH_RX_LO;
            end
          end
          PH_STOP_LO: st_d_o.phase = PH_STOP_HI;
          PH_STOP_HI: st_d_o.phase = PH_STOP_REL;
          default: begin
            // STOP released: a new START for a read, else finish
            if (st_q_i.header_step == HS_MID_STOP) begin
              st_d_o.header_step = HS_ADDR_R;
              st_d_o.phase       = PH_STA_HI;
            end else begin
              res_o.done_res  = 1'b1;
              res_o.ack_error = st_q_i.error_flag;
              st_d_o.phase    = PH_IDLE;
            end
          end
        endcase
      end
    end

    // Released line reads back high
    if (!res_o.sda_drive) begin
      res_o.sda_out = 1'b1;
    end
  end

endmodule

@@ sv/i2cm_out_buf.sv @@
// Result register with a skid stage, decoupling input stall from output stall.
// Depends on i2cm_pkg for the result type.
module i2cm_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_fire_i,
  input  i2cm_pkg::i2cm_res_t res_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output i2cm_pkg::i2cm_res_t out_res_o
);
  import i2cm_pkg::*;

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  i2cm_res_t out_res_q, out_res_d;
  i2cm_res_t skid_res_q, skid_res_d;
  logic      out_fire;

  assign out_fire = out_valid_q & ~out_stall_i;

  // Refill from skid, or capture the new result where there is room
  always_comb begin
    out_valid_d  = out_valid_q;
    out_res_d    = out_res_q;
    skid_valid_d = skid_valid_q;
    skid_res_d   = skid_res_q;
    if (out_fire) begin
      out_valid_d = 1'b0;
    end
    if (out_fire && skid_valid_q) begin
      out_valid_d  = 1'b1;
      out_res_d    = skid_res_q;
      skid_valid_d = 1'b0;
    end
    if (in_fire_i) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_d = 1'b1;
        skid_res_d   = res_i;
      end else begin
        out_valid_d = 1'b1;
        out_res_d   = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

@@ sv/i2c_master_register_access.sv @@
// I2C register-access master: one tick request in, one pin-level result out.
// Each result is registered in the output stage, or in the skid stage while the output stalls.
// Throughput: one tick per cycle while in_stall_o is low; the sequencer state updates in a single pass.
// A skid stage lets one more tick in while a result waits on the output stall.
// Reset (async, active low) returns the sequencer to idle and loads the
// device address 0x48 and a half period of 10 ticks.
module i2c_master_register_access (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  i2cm_pkg::i2cm_req_t                 in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output i2cm_pkg::i2cm_res_t                 out_res_o,
  input  logic                                cfg_we_i,
  input  logic [i2cm_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [i2cm_pkg::CfgDataWidth-1:0]   cfg_wdata_i
);
  import i2cm_pkg::*;

  logic [DevAddrWidth-1:0] dev_addr_q;
  logic [HalfWidth-1:0]    half_ticks_q;
  i2cm_state_t             st_q, st_d;
  i2cm_res_t               res;
  logic                    in_fire;
  logic                    buf_full;

  assign in_stall_o = buf_full;
  assign in_fire    = in_valid_i & ~buf_full;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q   <= DevAddrReset;
      half_ticks_q <= HalfReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgDevAddr:    dev_addr_q   <= cfg_wdata_i[DevAddrWidth-1:0];
        CfgHalfPeriod: half_ticks_q <= cfg_wdata_i[HalfWidth-1:0];
        default:       ;
      endcase
    end
  end

  // Sequencer state, advanced once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_IDLE, header_step: HS_ADDR_W, default: '0};
    end else if (in_fire) begin
      st_q <= st_d;
    end
  end

  i2cm_step u_step (
    .st_q_i       (st_q),
    .req_i        (in_req_i),
    .dev_addr_i   (dev_addr_q),
    .half_ticks_i (half_ticks_q),
    .st_d_o       (st_d),
    .res_o        (res)
  );

  i2cm_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule

@@ sv/i2cm_checker.sv @@
// Port-level checks for the I2C register-access master, bound to the top level.
// Depends on i2cm_pkg and i2c_master_register_access.
module i2cm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input i2cm_pkg::i2cm_res_t               out_res_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Done only closes a running transaction
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.done_res |-> out_res_o.busy_res)
    else $error("done without busy");

  // Error is reported only with done
  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.ack_error |-> out_res_o.done_res)
    else $error("ack error outside done");

  // A received byte is sampled with the data line released and SCL high
  a_rx_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.byte_valid |->
      !out_res_o.sda_drive && out_res_o.scl_out && out_res_o.busy_res)
    else $error("byte sampled while driving data");

endmodule

bind i2c_master_register_access i2cm_checker u_i2cm_checker (.*);
